/* design/radix_string_to_integer_assert.svh */
// Assertion helpers used by the checker file of this block.
`ifndef RADIX_STRING_TO_INTEGER_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_ASSERT_SVH

// Checked at every rising clock edge outside of reset.
`define RSTI_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked at every rising clock edge, reset included.
`define RSTI_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* design/rsti_pkg.sv */
`timescale 1ns / 1ps

package rsti_pkg;

   localparam int MAX_RADIX   = 16;
   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int SYM_COUNT   = 16;
   localparam int DIGIT_W     = 4;
   localparam int RADIX_W     = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX        = 2'd2;

   typedef enum logic [2:0] {
      CLS_END,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } cls_type;

   // The digit match is kept apart from the class, since a blank or a sign
   // may also be a digit symbol once the sign phase is over.
   typedef struct packed {
      cls_type            cls;
      logic               hit;
      logic [DIGIT_W-1:0] digit;
      logic [RADIX_W-1:0] radix;
      logic               alphabet_ok;
   } entry_type;

endpackage

/* design/rsti_if.sv */
`timescale 1ns / 1ps

interface rsti_req_if;
   logic                       valid;
   logic                       ready;
   logic [rsti_pkg::CHAR_W-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink (input valid, input character, output ready);
endinterface

interface rsti_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rsti_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface rsti_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rsti_pkg::CSR_INDEX_W-1:0] index;
   logic [rsti_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/rsti_front.sv */
`timescale 1ns / 1ps

module rsti_front (
   input  logic                clock,
   input  logic                reset,
   rsti_req_if.sink            req_chan,
   rsti_csr_if.sink            csr_chan,
   input  logic                queue_ready,
   output logic                push,
   output rsti_pkg::entry_type push_entry
);
   import rsti_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NL) || (c == CHAR_TAB) ||
             (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

   logic [CSR_DATA_W-1:0] sym_low_ff;
   logic [CSR_DATA_W-1:0] sym_high_ff;
   logic [RADIX_W-1:0]    radix_ff;

   logic [CHAR_W-1:0]  sym [SYM_COUNT];
   logic [RADIX_W-1:0] used_radix;
   logic               hit;
   logic [DIGIT_W-1:0] hit_digit;
   logic               alphabet_ok;
   logic [CHAR_W-1:0]  c;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         radix_ff    <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SYMBOLS_LOW:  sym_low_ff  <= csr_chan.data;
            CSR_SYMBOLS_HIGH: sym_high_ff <= csr_chan.data;
            CSR_RADIX:        radix_ff    <= csr_chan.data[RADIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < SYM_COUNT; k++) begin
         sym[k] = (k < SYM_COUNT / 2) ? sym_low_ff[8*(k % 8) +: 8]
                                      : sym_high_ff[8*(k % 8) +: 8];
      end
   end

   assign used_radix = (radix_ff > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_ff;
   assign c = req_chan.character;

   // Scanning from the top down leaves the lowest matching digit in place.
   always_comb begin
      hit       = 1'b0;
      hit_digit = '0;
      for (int k = SYM_COUNT - 1; k >= 0; k--) begin
         if ((RADIX_W'(k) < used_radix) && (sym[k] == c)) begin
            hit       = 1'b1;
            hit_digit = DIGIT_W'(k);
         end
      end
   end

   always_comb begin
      alphabet_ok = (used_radix >= RADIX_W'(2));
      for (int i = 0; i < SYM_COUNT; i++) begin
         if (RADIX_W'(i) < used_radix) begin
            if ((sym[i] == '0) || (sym[i] == CHAR_PLUS) || (sym[i] == CHAR_MINUS) ||
                is_space(sym[i])) begin
               alphabet_ok = 1'b0;
            end
            for (int j = i + 1; j < SYM_COUNT; j++) begin
               if ((RADIX_W'(j) < used_radix) && (sym[j] == sym[i])) begin
                  alphabet_ok = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      push_entry.hit         = hit;
      push_entry.digit       = hit_digit;
      push_entry.radix       = used_radix;
      push_entry.alphabet_ok = alphabet_ok;
      priority if (c == '0) begin
         push_entry.cls = CLS_END;
      end else if (is_space(c)) begin
         push_entry.cls = CLS_SPACE;
      end else if (c == CHAR_PLUS) begin
         push_entry.cls = CLS_PLUS;
      end else if (c == CHAR_MINUS) begin
         push_entry.cls = CLS_MINUS;
      end else if (hit) begin
         push_entry.cls = CLS_DIGIT;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end

   assign req_chan.ready = queue_ready;
   assign push           = req_chan.valid && queue_ready;

endmodule

/* design/rsti_queue.sv */
`timescale 1ns / 1ps

module rsti_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsti_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output rsti_pkg::entry_type head_entry
);
   import rsti_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/rsti_back.sv */
`timescale 1ns / 1ps

module rsti_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rsti_pkg::entry_type head_entry,
   output logic                pop,
   rsti_rsp_if.source          rsp_chan
);
   import rsti_pkg::*;

   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   logic [1:0]         phase_ff, phase_in, phase_eff;
   logic               negative_ff, negative_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [VALUE_W-1:0] product;
   logic [VALUE_W-1:0] signed_acc;
   logic               is_end;

   assign is_end = (head_entry.cls == CLS_END);
   // A terminator waits only when the output register still holds an untaken result.
   assign pop = head_valid && (!is_end || !rsp_valid_ff || rsp_chan.ready);

   assign product    = acc_ff * VALUE_W'(head_entry.radix);
   assign signed_acc = negative_ff ? (VALUE_W'(0) - acc_ff) : acc_ff;

   // Whitespace and sign phases hand a character they do not consume to the next phase.
   always_comb begin
      phase_eff = phase_ff;
      if ((phase_eff == PH_SPACE) && (head_entry.cls != CLS_SPACE)) begin
         phase_eff = PH_SIGN;
      end
      if ((phase_eff == PH_SIGN) && (head_entry.cls != CLS_PLUS) &&
          (head_entry.cls != CLS_MINUS)) begin
         phase_eff = PH_DIGIT;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      acc_in       = acc_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (pop) begin
         if (is_end) begin
            phase_in     = PH_SPACE;
            negative_in  = 1'b0;
            acc_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_value_in = head_entry.alphabet_ok ? signed_acc : '0;
         end else begin
            unique case (phase_eff)
               PH_SPACE: phase_in = PH_SPACE;
               PH_SIGN: begin
                  phase_in = PH_SIGN;
                  if (head_entry.cls == CLS_MINUS) begin
                     negative_in = !negative_ff;
                  end
               end
               PH_DIGIT: begin
                  if (head_entry.hit) begin
                     phase_in = PH_DIGIT;
                     acc_in   = product + VALUE_W'(head_entry.digit);
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: phase_in = PH_STOP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = $signed(rsp_value_ff);

endmodule

/* design/radix_string_to_integer.sv */
`timescale 1ns / 1ps
// Channel  Role    Payload                      Transfer
// req      sink    character (8 bits)           valid and ready high at clock edge
// rsp      source  value (32 bits, signed)      valid and ready high at clock edge
// csr      sink    index (2 bits), data (64)    valid and ready high, ready always high
//
// One character is taken every cycle while the queue has room; a taken terminator
// reaches the registered result through the queue.
// Reset is synchronous and clears the symbol registers, radix and string state.
// A waiting result stalls only terminators; the two-entry queue then fills and
// drops req ready until the result is taken.

module radix_string_to_integer (
   input  logic       clock,
   input  logic       reset,
   rsti_req_if.sink   req_chan,
   rsti_rsp_if.source rsp_chan,
   rsti_csr_if.sink   csr_chan
);
   import rsti_pkg::*;

   logic      push, push_ready, pop, head_valid;
   entry_type push_entry, head_entry;

   rsti_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .queue_ready (push_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   rsti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rsti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* design/rsti_checker.sv */
`timescale 1ns / 1ps
`include "radix_string_to_integer_assert.svh"

module rsti_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [rsti_pkg::VALUE_W-1:0] rsp_value
);
   import rsti_pkg::*;

   `RSTI_ASSERT(valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `RSTI_ASSERT(value_holds, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_value), "rsp moved")
   `RSTI_ASSERT_ALWAYS(reset_clears, clock, reset |=> !rsp_valid && req_ready, "reset not clean")
   // The queue can only fill up behind a result that is waiting to be taken.
   `RSTI_ASSERT(ready_idle, clock, reset, !rsp_valid |-> req_ready, "req stalled, no result")

endmodule

bind radix_string_to_integer rsti_checker u_rsti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.value)
);

/* dv/radix_string_to_integer_tb.sv */
`timescale 1ns / 1ps

module radix_string_to_integer_tb;
   import rsti_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 500;
   localparam int LIMIT_NS      = 5_000_000;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_HIGH  = 8'hFF;

   typedef enum logic [1:0] {
      SCAN_BLANK,
      SCAN_SIGN,
      SCAN_DIGIT,
      SCAN_DONE
   } scan_phase_type;

   typedef enum logic {
      ENTRY_CHAR,
      ENTRY_CSR
   } stim_kind_type;

   typedef struct {
      stim_kind_type           kind;
      logic [CHAR_W-1:0]      character;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } stim_entry_type;

   logic clock;
   logic reset;

   rsti_req_if req_bus ();
   rsti_rsp_if rsp_bus ();
   rsti_csr_if csr_bus ();

   radix_string_to_integer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Converter state as seen by the predictor.
   logic [CSR_DATA_W-1:0] cfg_low;
   logic [CSR_DATA_W-1:0] cfg_high;
   logic [RADIX_W-1:0]    cfg_radix;
   scan_phase_type        scan_phase;
   logic                  minus_odd;
   logic [VALUE_W-1:0]    magnitude;

   logic signed [VALUE_W-1:0] expected_values[$];
   stim_entry_type            stim_q[$];

   // Alphabet as the stimulus generator last programmed it.
   logic [CHAR_W-1:0] gen_sym[SYM_COUNT];
   int                gen_radix;
   int                chars_queued;

   int  mismatches;
   bit  req_next;
   bit  csr_next;
   int  send_gap;
   int  quiet_cycles;
   bit  calm_send;
   int  rsp_hold;
   bit  calm_recv;
   logic signed [VALUE_W-1:0] want_value;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic int radix_in_use();
      int r;
      r = int'(cfg_radix);
      return (r > MAX_RADIX) ? MAX_RADIX : r;
   endfunction

   function automatic logic [CHAR_W-1:0] symbol_at(input int k);
      return (k < 8) ? cfg_low[8*k +: 8] : cfg_high[8*(k-8) +: 8];
   endfunction

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_VT ||
             c == CH_FF || c == CH_CR;
   endfunction

   function automatic bit alphabet_ok();
      int r;
      int i;
      int j;
      logic [CHAR_W-1:0] s;
      r = radix_in_use();
      if (r < 2) return 1'b0;
      for (i = 0; i < r; i++) begin
         s = symbol_at(i);
         if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || is_blank(s)) return 1'b0;
         for (j = i + 1; j < r; j++)
            if (symbol_at(j) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   // A repeated symbol resolves to its lowest digit.
   function automatic int digit_value(input logic [CHAR_W-1:0] c);
      int k;
      for (k = 0; k < radix_in_use(); k++)
         if (symbol_at(k) == c) return k;
      return -1;
   endfunction

   function automatic void predict_char(input logic [CHAR_W-1:0] c);
      int d;
      logic [VALUE_W-1:0] v;
      if (c == CH_NUL) begin
         v = '0;
         if (alphabet_ok()) v = minus_odd ? (32'd0 - magnitude) : magnitude;
         expected_values.push_back(v);
         scan_phase = SCAN_BLANK;
         minus_odd  = 1'b0;
         magnitude  = '0;
         return;
      end
      if (scan_phase == SCAN_BLANK) begin
         if (is_blank(c)) return;
         scan_phase = SCAN_SIGN;
      end
      if (scan_phase == SCAN_SIGN) begin
         if (c == CH_MINUS) begin
            minus_odd = ~minus_odd;
            return;
         end
         if (c == CH_PLUS) return;
         scan_phase = SCAN_DIGIT;
      end
      if (scan_phase == SCAN_DIGIT) begin
         d = digit_value(c);
         if (d < 0) scan_phase = SCAN_DONE;
         else magnitude = magnitude * 32'(radix_in_use()) + 32'(d);
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_SYMBOLS_LOW: cfg_low = data;
         CSR_SYMBOLS_HIGH: cfg_high = data;
         CSR_RADIX: cfg_radix = data[RADIX_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic push_char(input logic [CHAR_W-1:0] c);
      stim_entry_type e;
      e.kind      = ENTRY_CHAR;
      e.character = c;
      e.index     = '0;
      e.data      = '0;
      stim_q.push_back(e);
      chars_queued++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   task automatic push_csr(input logic [CSR_INDEX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] data);
      stim_entry_type e;
      e.kind      = ENTRY_CSR;
      e.character = CH_NUL;
      e.index     = index;
      e.data      = data;
      stim_q.push_back(e);
   endtask

   // Packs gen_sym into the two symbol words and queues all three writes.
   task automatic commit_alphabet(input int radix_write);
      int k;
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      for (k = 0; k < 8; k++) begin
         lo[8*k +: 8] = gen_sym[k];
         hi[8*k +: 8] = gen_sym[k+8];
      end
      push_csr(CSR_SYMBOLS_LOW, lo);
      push_csr(CSR_SYMBOLS_HIGH, hi);
      push_csr(CSR_RADIX, CSR_DATA_W'(radix_write));
      gen_radix = (radix_write > MAX_RADIX) ? MAX_RADIX : radix_write;
   endtask

   task automatic set_alphabet(input string s, input int radix_write);
      int k;
      for (k = 0; k < SYM_COUNT; k++) gen_sym[k] = (k < s.len()) ? s[k] : CH_NUL;
      commit_alphabet(radix_write);
   endtask

   function automatic logic [CHAR_W-1:0] pick_forbidden();
      case ($urandom_range(0, 8))
         0: return CH_NUL;
         1: return CH_PLUS;
         2: return CH_MINUS;
         3: return CH_SPACE;
         4: return CH_TAB;
         5: return CH_LF;
         6: return CH_VT;
         7: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   task automatic random_alphabet();
      int kind;
      int r_eff;
      int r_write;
      int i;
      int j;
      bit clash;
      logic [CHAR_W-1:0] c;
      kind    = $urandom_range(0, 9);
      r_eff   = $urandom_range(2, MAX_RADIX);
      r_write = r_eff;
      if (kind == 0) begin
         r_eff   = MAX_RADIX;
         r_write = $urandom_range(MAX_RADIX, 31);
      end
      for (i = 0; i < SYM_COUNT; i++) gen_sym[i] = CHAR_W'($urandom_range(0, 255));
      for (i = 0; i < r_eff; i++) begin
         do begin
            c = CHAR_W'($urandom_range(1, 255));
            clash = is_blank(c) || c == CH_PLUS || c == CH_MINUS;
            for (j = 0; j < i; j++)
               if (gen_sym[j] == c) clash = 1'b1;
         end while (clash);
         gen_sym[i] = c;
      end
      if (kind == 7) begin
         r_write = $urandom_range(0, 1);
      end else if (kind == 8) begin
         i = $urandom_range(1, r_eff - 1);
         j = $urandom_range(0, i - 1);
         gen_sym[i] = gen_sym[j];
      end else if (kind == 9) begin
         gen_sym[$urandom_range(0, r_eff - 1)] = pick_forbidden();
      end
      commit_alphabet(r_write);
   endtask

   function automatic logic [CHAR_W-1:0] pick_digit();
      if (gen_radix == 0) return CHAR_W'($urandom_range(1, 255));
      return gen_sym[$urandom_range(0, gen_radix - 1)];
   endfunction

   task automatic random_string();
      int n;
      int i;
      int half;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) push_char(CHAR_W'($urandom_range(1, 255)));
      end else begin
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         for (i = 0; i < n; i++) push_char(pick_forbidden() == CH_NUL ? CH_SPACE : CH_TAB);
         if ($urandom_range(0, 3) == 0) push_char(CH_CR);
         n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
         for (i = 0; i < n; i++) push_char(($urandom_range(0, 1) == 0) ? CH_MINUS : CH_PLUS);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 7);
         half = n / 2;
         for (i = 0; i < n; i++) begin
            // Now and then the alphabet changes in the middle of a string.
            if (i == half && $urandom_range(0, 19) == 0) random_alphabet();
            push_char(pick_digit());
         end
         if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) push_char(CHAR_W'($urandom_range(1, 255)));
         end
      end
      push_char(CH_NUL);
      if ($urandom_range(0, 11) == 0) random_alphabet();
   endtask

   // Driver: characters go out from stim_q, register writes wait for a quiet block.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         send_gap     = 0;
         quiet_cycles = 0;
         cfg_low      = '0;
         cfg_high     = '0;
         cfg_radix    = '0;
         scan_phase   = SCAN_BLANK;
         minus_odd    = 1'b0;
         magnitude    = '0;
      end else begin
         req_next = req_bus.valid;
         csr_next = csr_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predict_char(req_bus.character);
            req_next     = 1'b0;
            quiet_cycles = 0;
         end else if (expected_values.size() != 0) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            apply_csr(csr_bus.index, csr_bus.data);
            csr_next = 1'b0;
         end
         if ($urandom_range(0, 63) == 0) calm_send = !calm_send;
         if (!req_next && !csr_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (stim_q.size() != 0) begin
               if (stim_q[0].kind == ENTRY_CHAR) begin
                  req_next = 1'b1;
                  req_bus.character <= stim_q[0].character;
                  void'(stim_q.pop_front());
                  send_gap = calm_send ? 0 : pick_gap();
               end else if (quiet_cycles >= SETTLE_CYCLES && expected_values.size() == 0) begin
                  csr_next = 1'b1;
                  csr_bus.index <= stim_q[0].index;
                  csr_bus.data  <= stim_q[0].data;
                  void'(stim_q.pop_front());
               end
            end
         end
         req_bus.valid <= req_next;
         csr_bus.valid <= csr_next;
      end
   end

   // Monitor: result items against the oldest expected value, with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", rsp_bus.value));
            end else begin
               want_value = expected_values.pop_front();
               if (rsp_bus.value !== want_value)
                  report_mismatch($sformatf("value %0d, expected %0d", rsp_bus.value,
                                            want_value));
            end
         end
         if ($urandom_range(0, 63) == 0) calm_recv = !calm_recv;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm_recv) rsp_hold = pick_gap();
         end
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.character = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      mismatches        = 0;
      chars_queued      = 0;
      gen_radix         = 0;
      calm_send         = 1'b0;
      calm_recv         = 1'b0;

      // Decimal: every blank, a sign run, a digit, a stop on 0xFF, then an empty string.
      set_alphabet("0123456789", 10);
      push_char(CH_SPACE);
      push_char(CH_LF);
      push_char(CH_TAB);
      push_char(CH_VT);
      push_char(CH_FF);
      push_char(CH_CR);
      push_char(CH_MINUS);
      push_char(CH_PLUS);
      push_char(CH_MINUS);
      push_text("9");
      push_char(CH_HIGH);
      push_text("5");
      push_char(CH_NUL);
      push_char(CH_NUL);

      // Hex with an oversized radix; the accumulator fills all 32 bits, then the radix
      // drops to ten in the middle of the string so F stops the conversion.
      set_alphabet("0123456789ABCDEF", 31);
      push_text("-FFFFFFFF");
      push_csr(CSR_RADIX, CSR_DATA_W'(10));
      gen_radix = 10;
      push_text("F9");
      push_char(CH_NUL);

      // Repeated symbol, then all-ones symbol words with a radix of one.
      set_alphabet("0120", 4);
      push_text("20");
      push_char(CH_NUL);
      set_alphabet("", 1);
      for (int k = 0; k < SYM_COUNT; k++) gen_sym[k] = CH_HIGH;
      commit_alphabet(1);
      push_char(CH_HIGH);
      push_char(CH_NUL);

      random_alphabet();
      chars_queued = 0;
      while (chars_queued < RANDOM_ITEMS) random_string();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_bus.valid || csr_bus.valid ||
             expected_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS * 1ns);
      $display("TB_ERROR");
      $finish;
   end

endmodule
